/* sv/arpc_pkg.sv */
// arpc_pkg: shared types and constants for the arp cache engine
package arpc_pkg;

  // opcode words of a received packet
  localparam logic [15:0] OP_REQUEST = 16'h0100;
  localparam logic [15:0] OP_REPLY   = 16'h0200;

  // register reset values
  localparam logic [31:0] LOCAL_IP_RESET    = 32'h0000_0000;
  localparam logic [31:0] SUBNET_MASK_RESET = 32'h00FF_FFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_LOCAL_IP    = 2'd0;
  localparam logic [1:0] CFG_SUBNET_MASK = 2'd1;

  // broadcast entry held in entry 0
  localparam logic [31:0] BCAST_IP  = 32'hFFFF_FFFF;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_HIT     = 3'd0,
    KIND_REQUEST = 3'd1,
    KIND_GATEWAY = 3'd2,
    KIND_LEARNED = 3'd3,
    KIND_REPLY   = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_t;

  // work class decided by the front end
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_REPLY  = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    logic        action;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    logic [15:0] opcode;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] mac_out;
    logic [31:0] ip_out;
    logic        table_full;
  } out_item_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        local_net;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* sv/arp_cache_engine_unit.sv */
// arp_cache_engine_unit: ipv4 to mac cache with lookup and learning
// the result follows a linear scan that reads one entry per cycle and ends on the first match or
//   after the last valid entry; an ignored opcode skips the scan; items may wait queued behind others
// the scan handles one item at a time, and the next is taken from the queue only when the back end is
//   idle; start is accepted while the queue has room; busy while the two-entry queue is full
// reset (rst, synchronous): entry 0 broadcast, count one, no clearing pass; results never stall
module arp_cache_engine_unit #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  arpc_pkg::in_item_t  request,
  output logic                done,
  output arpc_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import arpc_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      cmd;
  cmd_t      head;
  q_status_t q_stat;

  arpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  arpc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd),
    .pop     (pop),
    .cmd_out (head),
    .q_stat  (q_stat)
  );

  arpc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

`ifndef ASSERT_OFF
  // queue can never be full and empty together
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // a dropped entry only comes from learning
  a_full_kind: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |->
      (result.kind == KIND_LEARNED || result.kind == KIND_REPLY))
    else $error("table_full on a non-learning result");

  // a send-request result carries no mac
  a_request_mac: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_REQUEST) |-> (result.mac_out == '0))
    else $error("request result with nonzero mac");

  // no pop from an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

/* sv/arpc_ram.sv */
// arpc_ram: generic single write port memory with registered read
module arpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/arpc_front.sv */
// arpc_front: configuration registers and classification of incoming items
module arpc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  arpc_pkg::in_item_t request,
  input  arpc_pkg::q_status_t q_stat,
  output logic             busy,
  output logic             push,
  output arpc_pkg::cmd_t   cmd,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import arpc_pkg::*;

  logic [31:0] local_ip;
  logic [31:0] subnet_mask;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip    <= LOCAL_IP_RESET;
      subnet_mask <= SUBNET_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LOCAL_IP) begin
        local_ip <= cfg_data;
      end else if (cfg_index == CFG_SUBNET_MASK) begin
        subnet_mask <= cfg_data;
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = q_stat.full;
  assign push      = start && !busy;

  // classify the item
  always_comb begin
    cmd.ip        = request.ip_address;
    cmd.mac       = request.mac_address;
    cmd.local_net = (request.ip_address & subnet_mask) == (local_ip & subnet_mask);
    if (!request.action) begin
      cmd.op = CMD_LOOKUP;
    end else if (request.opcode == OP_REPLY) begin
      cmd.op = CMD_LEARN;
    end else if (request.opcode == OP_REQUEST) begin
      cmd.op = CMD_REPLY;
    end else begin
      cmd.op = CMD_IGNORE;
    end
  end

endmodule

/* sv/arpc_queue.sv */
// arpc_queue: two-entry command queue between front and back
module arpc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  arpc_pkg::cmd_t   cmd_in,
  input  logic             pop,
  output arpc_pkg::cmd_t   cmd_out,
  output arpc_pkg::q_status_t q_stat
);
  import arpc_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign cmd_out      = slot[rd_ptr];
  assign q_stat.full  = fill == 2'd2;
  assign q_stat.empty = fill == 2'd0;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

endmodule

/* sv/arpc_back.sv */
// arpc_back: table scan, learn and result generation
module arpc_back #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  arpc_pkg::cmd_t      head,
  input  arpc_pkg::q_status_t q_stat,
  output logic                pop,
  output logic                done,
  output arpc_pkg::out_item_t result
);
  import arpc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t          state;
  state_t          state_next;
  cmd_t            cur;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   count;
  logic            cmp_valid;
  logic [AW-1:0]   cmp_idx;
  logic [47:0]     e0_mac;
  logic [47:0]     e1_mac;
  logic [31:0]     ip_rd;
  logic [47:0]     mac_rd;
  logic [31:0]     ip_cmp;
  logic [47:0]     mac_hit;
  logic            issue_ok;
  logic            match;
  logic            scan_end;
  logic            is_learn;
  logic            ip_we;
  logic            mac_we;
  logic            append;
  logic            dropped;
  logic [AW-1:0]   wr_addr;
  logic            done_next;
  out_item_t       result_next;

  arpc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ip_ram (
    .clk     (clk),
    .we      (ip_we),
    .wr_addr (wr_addr),
    .wr_data (cur.ip),
    .rd_addr (idx[AW-1:0]),
    .rd_data (ip_rd)
  );

  arpc_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_mac_ram (
    .clk     (clk),
    .we      (mac_we),
    .wr_addr (wr_addr),
    .wr_data (cur.mac),
    .rd_addr (idx[AW-1:0]),
    .rd_data (mac_rd)
  );

  // entry 0 is broadcast and never read from memory
  assign ip_cmp   = (cmp_idx == '0) ? BCAST_IP : ip_rd;
  assign mac_hit  = (cmp_idx == '0) ? e0_mac : mac_rd;
  assign issue_ok = idx < count;
  assign match    = cmp_valid && (ip_cmp == cur.ip);
  assign scan_end = match || (cmp_valid && ((CW'(cmp_idx) + CW'(1)) == count));
  assign is_learn = (cur.op == CMD_LEARN) || (cur.op == CMD_REPLY);
  assign pop      = (state == S_IDLE) && !q_stat.empty;

  // table update at the end of a scan
  always_comb begin
    ip_we   = 1'b0;
    mac_we  = 1'b0;
    append  = 1'b0;
    dropped = 1'b0;
    wr_addr = cmp_idx;
    if (state == S_SCAN && scan_end && is_learn) begin
      if (match) begin
        mac_we = 1'b1;
      end else if (count == CW'(TABLE_DEPTH)) begin
        dropped = 1'b1;
      end else begin
        ip_we   = 1'b1;
        mac_we  = 1'b1;
        append  = 1'b1;
        wr_addr = count[AW-1:0];
      end
    end
  end

  // sequencer and result
  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    result_next = '{kind: KIND_IGNORED, mac_out: '0, ip_out: '0, table_full: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          if (head.op == CMD_IGNORE) begin
            done_next = 1'b1;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          case (cur.op)
            CMD_LOOKUP: begin
              if (match) begin
                result_next.kind    = KIND_HIT;
                result_next.mac_out = mac_hit;
              end else if (cur.local_net) begin
                result_next.kind   = KIND_REQUEST;
                result_next.ip_out = cur.ip;
              end else begin
                result_next.kind    = KIND_GATEWAY;
                result_next.mac_out = e1_mac;
              end
            end
            CMD_LEARN: begin
              result_next.kind       = KIND_LEARNED;
              result_next.table_full = dropped;
            end
            CMD_REPLY: begin
              result_next.kind       = KIND_REPLY;
              result_next.mac_out    = cur.mac;
              result_next.ip_out     = cur.ip;
              result_next.table_full = dropped;
            end
            default: begin
              result_next.kind = KIND_IGNORED;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      count     <= CW'(1);
      cmp_valid <= 1'b0;
      idx       <= '0;
      e0_mac    <= BCAST_MAC;
      e1_mac    <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_IDLE) begin
        idx       <= '0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= issue_ok;
        if (issue_ok) begin
          idx <= idx + CW'(1);
        end
      end
      if (append) begin
        count <= count + CW'(1);
      end
      // mirrors of the broadcast and gateway macs
      if (mac_we && wr_addr == AW'(0)) begin
        e0_mac <= cur.mac;
      end
      if (mac_we && wr_addr == AW'(1)) begin
        e1_mac <= cur.mac;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_SCAN) begin
      cmp_idx <= idx[AW-1:0];
    end
    result <= result_next;
  end

endmodule

/* tb/tb.sv */
// tb: self-checking regression for the arp cache engine
module tb;
  import arpc_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int GAP_MAX     = 30;
  // register indexes past the last one, writes there must be dropped
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    request   = '0;
  logic        done;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_LOCAL_IP;
  logic [31:0] cfg_data  = '0;

  // predicted cache contents and register copies
  logic [31:0] cache_ip  [TABLE_DEPTH];
  logic [47:0] cache_mac [TABLE_DEPTH];
  int          cache_count;
  logic [31:0] cfg_local_ip;
  logic [31:0] cfg_subnet_mask;

  out_item_t   expected_results [$];
  int          failures  = 0;
  int          cycles    = 0;
  int          idle_pct  = 20;

  arp_cache_engine_unit #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("arp_cache_engine_unit regression: fail");
      $finish;
    end
  end

  // cache state after reset
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cache_ip[i]  = '0;
      cache_mac[i] = '0;
    end
    cache_ip[0]     = BCAST_IP;
    cache_mac[0]    = BCAST_MAC;
    cache_count     = 1;
    cfg_local_ip    = LOCAL_IP_RESET;
    cfg_subnet_mask = SUBNET_MASK_RESET;
  end

  // index of the first valid entry holding addr, or cache_count on a miss
  function automatic int cache_find(logic [31:0] addr);
    for (int i = 0; i < cache_count; i++) begin
      if (cache_ip[i] == addr) return i;
    end
    return cache_count;
  endfunction

  // expected result of one item, updating the predicted cache
  function automatic out_item_t predict_arp(in_item_t it);
    out_item_t r;
    int        idx;
    r   = '0;
    idx = cache_find(it.ip_address);
    if (!it.action) begin
      if (idx < cache_count) begin
        r.kind    = KIND_HIT;
        r.mac_out = cache_mac[idx];
      end else if ((it.ip_address & cfg_subnet_mask) == (cfg_local_ip & cfg_subnet_mask)) begin
        r.kind   = KIND_REQUEST;
        r.ip_out = it.ip_address;
      end else begin
        r.kind    = KIND_GATEWAY;
        r.mac_out = cache_mac[1];
      end
    end else if (it.opcode == OP_REPLY || it.opcode == OP_REQUEST) begin
      if (idx < cache_count) begin
        cache_mac[idx] = it.mac_address;
      end else if (cache_count >= TABLE_DEPTH) begin
        r.table_full = 1'b1;
      end else begin
        cache_ip[cache_count]  = it.ip_address;
        cache_mac[cache_count] = it.mac_address;
        cache_count++;
      end
      if (it.opcode == OP_REPLY) begin
        r.kind = KIND_LEARNED;
      end else begin
        r.kind    = KIND_REPLY;
        r.mac_out = it.mac_address;
        r.ip_out  = it.ip_address;
      end
    end else begin
      r.kind = KIND_IGNORED;
    end
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [47:0] m;
    m[47:32] = 16'($urandom_range(16'hFFFF));
    m[31:0]  = $urandom();
    return m;
  endfunction

  function automatic in_item_t make_item(logic act, logic [31:0] ip, logic [47:0] mac,
                                         logic [15:0] op);
    in_item_t it;
    it.action      = act;
    it.ip_address  = ip;
    it.mac_address = mac;
    it.opcode      = op;
    return it;
  endfunction

  // address not yet in the cache
  function automatic logic [31:0] fresh_ip();
    logic [31:0] ip;
    do ip = $urandom(); while (cache_find(ip) < cache_count);
    return ip;
  endfunction

  // mostly well-formed traffic: lookups of known, local and random addresses, learning,
  // and some packets with broken opcodes
  function automatic in_item_t make_random_item();
    in_item_t it;
    int       pick;
    int       sub;
    it   = make_item(1'b0, $urandom(), rand_mac(), 16'($urandom_range(16'hFFFF)));
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    if (pick < 45) begin
      if (sub < 50) begin
        it.ip_address = cache_ip[$urandom_range(cache_count - 1)];
      end else if (sub < 75) begin
        it.ip_address = (cfg_local_ip & cfg_subnet_mask) | ($urandom() & ~cfg_subnet_mask);
      end else if (sub >= 95) begin
        it.ip_address = BCAST_IP;
      end
    end else if (pick < 88) begin
      it.action = 1'b1;
      it.opcode = (sub < 50) ? OP_REPLY : OP_REQUEST;
      if ($urandom_range(1)) it.ip_address = cache_ip[$urandom_range(cache_count - 1)];
    end else begin
      it.action = 1'b1;
      // near misses of the reply opcode, else any word
      if (sub < 50) it.opcode = OP_REPLY ^ (16'h1 << $urandom_range(15));
    end
    return it;
  endfunction

  // send one item, record its expected result, then idle at random
  task automatic issue_item(in_item_t it);
    int gap;
    start   <= 1'b1;
    request <= it;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_arp(it));
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off new items until every pending result has come back
  task automatic wait_results_drained();
    start <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk);
  endtask

  // register write, only called with the engine idle
  task automatic write_cfg_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOCAL_IP:    cfg_local_ip = val;
      CFG_SUBNET_MASK: cfg_subnet_mask = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_subnet(logic [31:0] ip, logic [31:0] mask);
    wait_results_drained();
    write_cfg_reg(CFG_LOCAL_IP, ip);
    write_cfg_reg(CFG_SUBNET_MASK, mask);
  endtask

  // broadcast entry, unlearned gateway and local misses straight after reset
  task automatic test_reset_state();
    issue_item(make_item(1'b0, BCAST_IP, '0, '0));
    issue_item(make_item(1'b0, 32'h0A00_0001, '0, '0));
    issue_item(make_item(1'b0, 32'h1200_0000, '0, '0));
    // zeroed entries past the count must not match
    issue_item(make_item(1'b0, 32'h0000_0000, '0, '0));
  endtask

  // gateway learning, request and reply packets, updates, ignored opcodes
  task automatic test_learning();
    issue_item(make_item(1'b1, 32'h0A00_00FE, 48'h0201_0203_0405, OP_REPLY));
    issue_item(make_item(1'b0, 32'h0B00_0001, '0, '0));
    issue_item(make_item(1'b1, 32'h0000_0042, 48'hA5A5_5A5A_0F0F, OP_REQUEST));
    issue_item(make_item(1'b0, 32'h0000_0042, '1, OP_REQUEST));
    issue_item(make_item(1'b1, 32'h0000_0042, 48'h5A5A_A5A5_F0F0, OP_REPLY));
    issue_item(make_item(1'b0, 32'h0000_0042, '1, '1));
    issue_item(make_item(1'b1, BCAST_IP, '0, OP_REPLY));
    issue_item(make_item(1'b0, BCAST_IP, '0, '0));
    issue_item(make_item(1'b1, 32'h0000_0000, '1, OP_REQUEST));
    issue_item(make_item(1'b0, 32'h0000_0000, '0, '0));
    issue_item(make_item(1'b1, 32'h0000_0077, '1, 16'h0000));
    issue_item(make_item(1'b1, 32'h0000_0077, '1, 16'hFFFF));
    issue_item(make_item(1'b1, 32'h0000_0077, '1, 16'h0001));
    issue_item(make_item(1'b1, 32'h0000_0077, '1, 16'h0201));
    issue_item(make_item(1'b0, 32'h0000_0077, '0, '0));
  endtask

  // mask extremes and writes to unused register indexes
  task automatic test_config_extremes();
    set_subnet('1, '1);
    issue_item(make_item(1'b0, 32'hFFFF_FFFE, '0, '0));
    set_subnet('0, '0);
    issue_item(make_item(1'b0, 32'hDEAD_BEEF, '0, '0));
    wait_results_drained();
    write_cfg_reg(CFG_SPARE_A, '1);
    write_cfg_reg(CFG_SPARE_B, '1);
    issue_item(make_item(1'b0, 32'h8000_0001, '0, '0));
    set_subnet(32'hC0A8_0105, 32'hFFFF_FF00);
    issue_item(make_item(1'b0, 32'hC0A8_01FF, '0, '0));
  endtask

  // random traffic in blocks, each under a fresh subnet setting
  task automatic test_random(int count);
    int          sel;
    logic [31:0] mask;
    for (int b = 0; b < 3; b++) begin
      sel = $urandom_range(4);
      case (sel)
        0:       mask = 32'hFFFF_FF00;
        1:       mask = '0;
        2:       mask = '1;
        3:       mask = SUBNET_MASK_RESET;
        default: mask = $urandom();
      endcase
      set_subnet($urandom_range(1) ? $urandom() : ($urandom_range(1) ? '1 : '0), mask);
      for (int n = 0; n < count / 3; n++) issue_item(make_random_item());
    end
  endtask

  // fill every entry, then learn past the end of the table
  task automatic test_table_full();
    logic [31:0] dropped;
    while (cache_count < TABLE_DEPTH) begin
      issue_item(make_item(1'b1, fresh_ip(), rand_mac(),
                           $urandom_range(1) ? OP_REPLY : OP_REQUEST));
    end
    dropped = fresh_ip();
    issue_item(make_item(1'b1, dropped, rand_mac(), OP_REPLY));
    issue_item(make_item(1'b1, dropped, rand_mac(), OP_REQUEST));
    issue_item(make_item(1'b0, dropped, '0, '0));
    // updates still work on a full table, deepest entry included
    issue_item(make_item(1'b1, cache_ip[TABLE_DEPTH - 1], rand_mac(), OP_REPLY));
    issue_item(make_item(1'b0, cache_ip[TABLE_DEPTH - 1], '0, '0));
    issue_item(make_item(1'b1, cache_ip[1], rand_mac(), OP_REQUEST));
    issue_item(make_item(1'b0, $urandom(), '0, '0));
  endtask

  // compare each result strobe with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending: kind %0d", result.kind);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (result.kind !== want.kind) begin
          $error("kind: expected %0d got %0d", want.kind, result.kind);
          failures++;
        end
        if (result.mac_out !== want.mac_out) begin
          $error("mac_out: expected %h got %h", want.mac_out, result.mac_out);
          failures++;
        end
        if (result.ip_out !== want.ip_out) begin
          $error("ip_out: expected %h got %h", want.ip_out, result.ip_out);
          failures++;
        end
        if (result.table_full !== want.table_full) begin
          $error("table_full: expected %0d got %0d", want.table_full, result.table_full);
          failures++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_learning();
    test_config_extremes();
    idle_pct = 20;
    test_random(600);
    test_table_full();
    idle_pct = 78;
    test_random(600);
    idle_pct = 0;
    test_random(600);
    wait_results_drained();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (failures == 0) begin
      $display("arp_cache_engine_unit regression: pass");
    end else begin
      $display("arp_cache_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
